>>> hw/rtl/fgcf_pkg.sv
// ----------------------------------------------------------------------------
// fgcf_pkg
// Shared types, constants and the control store of the cycle finder.
// ----------------------------------------------------------------------------
package fgcf_pkg;

   localparam int NODE_COUNT = 64;
   localparam int NODE_W     = 6;
   localparam int LEN_W      = 7;
   localparam int ADDR_W     = $clog2(NODE_COUNT);
   localparam int STEP_W     = 4;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ADDR_START,
      ADDR_SLOW,
      ADDR_FAST,
      ADDR_RD,
      ADDR_WALK
   } addr_sel_type;

   typedef enum logic [1:0] {
      SLOW_HOLD,
      SLOW_RD,
      SLOW_START
   } slow_op_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_QUERY,
      COND_EQ,
      COND_LAST
   } cond_type;

   typedef struct packed {
      addr_sel_type      addr_sel;
      slow_op_type       slow_op;
      logic              fast_ld;
      logic              walk_init;
      logic              walk_step;
      logic              wait_out;
      logic              req_ready;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic no_query;
      logic eq;
      logic last;
      logic out_busy;
   } status_type;

   // control store: one word per step
   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '{addr_sel: ADDR_START, slow_op: SLOW_HOLD, fast_ld: 1'b0, walk_init: 1'b0,
            walk_step: 1'b0, wait_out: 1'b0, req_ready: 1'b0, cond: COND_NONE,
            target: '0};
      unique case (step)
         4'd0: begin
            // idle: take words, stay here unless a query starts
            w.req_ready = 1'b1;
            w.cond      = COND_NO_QUERY;
            w.target    = 4'd0;
         end
         4'd1: w.addr_sel = ADDR_START;
         4'd2: begin
            w.addr_sel = ADDR_RD;
            w.slow_op  = SLOW_RD;
         end
         4'd3: w.fast_ld = 1'b1;
         // tortoise one step, hare two
         4'd4: begin
            w.addr_sel = ADDR_SLOW;
            w.cond     = COND_EQ;
            w.target   = 4'd8;
         end
         4'd5: begin
            w.addr_sel = ADDR_FAST;
            w.slow_op  = SLOW_RD;
         end
         4'd6: w.addr_sel = ADDR_RD;
         4'd7: begin
            w.fast_ld = 1'b1;
            w.cond    = COND_ALWAYS;
            w.target  = 4'd4;
         end
         // restart tortoise at the start, both one step
         4'd8: w.slow_op = SLOW_START;
         4'd9: begin
            w.addr_sel = ADDR_SLOW;
            w.cond     = COND_EQ;
            w.target   = 4'd12;
         end
         4'd10: begin
            w.addr_sel = ADDR_FAST;
            w.slow_op  = SLOW_RD;
         end
         4'd11: begin
            w.fast_ld = 1'b1;
            w.cond    = COND_ALWAYS;
            w.target  = 4'd9;
         end
         // walk the cycle from its entry
         4'd12: w.walk_init = 1'b1;
         4'd13: w.addr_sel = ADDR_WALK;
         4'd14: begin
            w.addr_sel  = ADDR_WALK;
            w.walk_step = 1'b1;
            w.wait_out  = 1'b1;
            w.cond      = COND_LAST;
            w.target    = 4'd0;
         end
         4'd15: begin
            w.cond   = COND_ALWAYS;
            w.target = 4'd13;
         end
         default: w.cond = COND_NONE;
      endcase
      return w;
   endfunction

endpackage

>>> hw/rtl/fgcf_seq.sv
// ----------------------------------------------------------------------------
// fgcf_seq
// Step counter over the control store, with conditional jumps and hold.
// ----------------------------------------------------------------------------
module fgcf_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  fgcf_pkg::status_type   status,
   output fgcf_pkg::ctrl_word_type ctrl,
   output logic                   run
);

   logic [fgcf_pkg::STEP_W-1:0] step_ff;
   logic [fgcf_pkg::STEP_W-1:0] step_in;
   logic                        jump;

   assign ctrl = fgcf_pkg::ucode(step_ff);
   assign run  = !(ctrl.wait_out && status.out_busy);

   always_comb begin
      unique case (ctrl.cond)
         fgcf_pkg::COND_NONE:     jump = 1'b0;
         fgcf_pkg::COND_ALWAYS:   jump = 1'b1;
         fgcf_pkg::COND_NO_QUERY: jump = status.no_query;
         fgcf_pkg::COND_EQ:       jump = status.eq;
         fgcf_pkg::COND_LAST:     jump = status.last;
         default:                 jump = 1'b0;
      endcase
   end

   always_comb begin
      if (!run) begin
         step_in = step_ff;
      end else if (jump) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

>>> hw/rtl/functional_graph_cycle_finder.sv
// ----------------------------------------------------------------------------
// functional_graph_cycle_finder
// Successor table with a microcoded tortoise-and-hare search; streams out
// the nodes of the cycle reached from a start node, entry node first.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | contents
//  req     | in  | tvalid/tready       | tuser cmd, tdata node/successor
//  rsp     | out | tvalid/tready/tlast | tdata cycle_node/cycle_length
//
// load words are taken back to back while idle; the steps of a query are all
// bound by the single read port of the successor table.
// reset clears the step counter and output valid; the table is not cleared.
// a stalled result holds the walk; new words are taken only when idle.
// ----------------------------------------------------------------------------
module functional_graph_cycle_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // node[5:0], successor[11:6], zero
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // cycle_node[5:0], cycle_length[12:6], zero
   output logic        rsp_tlast
);

   localparam int NW = fgcf_pkg::NODE_W;
   localparam int LW = fgcf_pkg::LEN_W;
   localparam int AW = fgcf_pkg::ADDR_W;

   fgcf_pkg::ctrl_word_type ctrl;
   fgcf_pkg::status_type    status;
   logic                    run;

   logic [NW-1:0] req_node;
   logic [NW-1:0] req_succ;
   logic [NW-1:0] succ_sat;
   logic          accept;
   logic          in_range;
   logic          load_go;
   logic          query_go;

   logic [NW-1:0] succ_mem [fgcf_pkg::NODE_COUNT];
   logic [NW-1:0] rd_addr;
   logic [NW-1:0] rd_ff;

   logic [NW-1:0] start_ff;
   logic [NW-1:0] start_in;
   logic [NW-1:0] slow_ff;
   logic [NW-1:0] slow_in;
   logic [NW-1:0] fast_ff;
   logic [NW-1:0] fast_in;
   logic [NW-1:0] walk_ff;
   logic [NW-1:0] walk_in;
   logic [NW-1:0] entry_ff;
   logic [NW-1:0] entry_in;
   logic [LW-1:0] length_ff;
   logic [LW-1:0] length_in;
   logic [LW-1:0] length_inc;
   logic          last;

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [NW-1:0] rsp_node_ff;
   logic [NW-1:0] rsp_node_in;
   logic [LW-1:0] rsp_len_ff;
   logic [LW-1:0] rsp_len_in;
   logic          rsp_last_ff;
   logic          rsp_last_in;

   fgcf_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .run    (run)
   );

   assign req_node = req_tdata[NW-1:0];
   assign req_succ = req_tdata[2*NW-1:NW];
   assign req_tready = ctrl.req_ready;
   assign accept   = req_tvalid && req_tready;
   assign in_range = {1'b0, req_node} < LW'(fgcf_pkg::NODE_COUNT);
   assign load_go  = accept && in_range && (req_tuser == fgcf_pkg::CMD_LOAD);
   assign query_go = accept && in_range && (req_tuser == fgcf_pkg::CMD_QUERY);
   assign succ_sat = ({1'b0, req_succ} < LW'(fgcf_pkg::NODE_COUNT)) ?
                     req_succ : NW'(fgcf_pkg::NODE_COUNT - 1);

   // last node once the successor is the entry, or the run is full
   assign length_inc = length_ff + 1'b1;
   assign last = (rd_ff == entry_ff) || (length_inc == LW'(fgcf_pkg::NODE_COUNT));

   assign status.no_query = !query_go;
   assign status.eq       = (slow_ff == fast_ff);
   assign status.last     = last;
   assign status.out_busy = rsp_valid_ff && !rsp_tready;

   always_comb begin
      case (ctrl.addr_sel)
         fgcf_pkg::ADDR_START: rd_addr = start_ff;
         fgcf_pkg::ADDR_SLOW:  rd_addr = slow_ff;
         fgcf_pkg::ADDR_FAST:  rd_addr = fast_ff;
         fgcf_pkg::ADDR_RD:    rd_addr = rd_ff;
         fgcf_pkg::ADDR_WALK:  rd_addr = walk_ff;
         default:              rd_addr = start_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_go) begin
         succ_mem[req_node[AW-1:0]] <= succ_sat;
      end
      rd_ff <= succ_mem[rd_addr[AW-1:0]];
   end

   always_comb begin
      start_in  = query_go ? req_node : start_ff;
      slow_in   = slow_ff;
      fast_in   = fast_ff;
      walk_in   = walk_ff;
      entry_in  = entry_ff;
      length_in = length_ff;
      case (ctrl.slow_op)
         fgcf_pkg::SLOW_RD:    slow_in = rd_ff;
         fgcf_pkg::SLOW_START: slow_in = start_ff;
         default:              slow_in = slow_ff;
      endcase
      if (ctrl.fast_ld) begin
         fast_in = rd_ff;
      end
      if (ctrl.walk_init) begin
         walk_in   = slow_ff;
         entry_in  = slow_ff;
         length_in = '0;
      end
      if (ctrl.walk_step && run) begin
         walk_in   = rd_ff;
         length_in = length_inc;
      end
   end

   // output register: one word held until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_node_in  = rsp_node_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      if (ctrl.walk_step && run) begin
         rsp_valid_in = 1'b1;
         rsp_node_in  = walk_ff;
         rsp_len_in   = last ? length_inc : '0;
         rsp_last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff    <= start_in;
      slow_ff     <= slow_in;
      fast_ff     <= fast_in;
      walk_ff     <= walk_in;
      entry_ff    <= entry_in;
      length_ff   <= length_in;
      rsp_node_ff <= rsp_node_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(16 - NW - LW)'(0), rsp_len_ff, rsp_node_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
